/* src/fpa_pkg.sv */
// Shared constants and types for the fixed-point ALU.
// No dependencies; used by every module in src/.
package fpa_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_W         = 5;
    localparam int MAX_FRAC       = 31;
    localparam int PIPE_EXTRA     = 4;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 5'd16;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_NEG  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;
    localparam logic [2:0] OP_CONV = 3'd5;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg;
        logic dz;
    } ctrl_t;

endpackage

/* src/fixed_point_alu_core.sv */
// Top level of the Q-format fixed-point ALU: front stages and divider chain.
// Depends on fpa_pkg and fpa_div_cell.
//
// Usage:
//   Input: an item is taken on a clock edge with start high; busy is always
//   low, so one beat per cycle is accepted with no gaps.
//   Config: cfg_data (fraction bits) is written when cfg_valid and cfg_ready
//   are high; cfg_ready is always high. Write only while no item is in flight.
//   Output: result and div_by_zero are valid for one cycle with result_valid.
//   Timing: the same for every operation; each item passes the three front
//   stages, then the divider chain of DATA_WIDTH + 31 cells, one quotient
//   bit per cell, and then the output register.
//   Throughput: one beat per cycle.
//   Reset: all valid flags clear, fraction bits return to 16.
//   The receiver cannot stall; each result is shown exactly once.
module fixed_point_alu_core #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 operation,
    input  logic signed [31:0]         operand_a,
    input  logic signed [31:0]         operand_b,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fpa_pkg::FRAC_W-1:0] cfg_data,
    output logic                       result_valid,
    output logic signed [31:0]         result,
    output logic                       div_by_zero
);

    localparam int W     = DATA_WIDTH;
    localparam int NUM_W = DATA_WIDTH + fpa_pkg::MAX_FRAC;

    logic [fpa_pkg::FRAC_W-1:0] frac_reg;

    logic                       v0_reg;
    logic [2:0]                 op0_reg;
    logic signed [W-1:0]        a0_reg;
    logic signed [W-1:0]        b0_reg;
    logic [fpa_pkg::FRAC_W-1:0] fb0_reg;

    logic                       v1_reg;
    logic [2:0]                 op1_reg;
    logic signed [W-1:0]        a1_reg;
    logic signed [W-1:0]        b1_reg;
    logic [fpa_pkg::FRAC_W-1:0] fb1_reg;
    logic signed [2*W-1:0]      prod_reg;

    fpa_pkg::ctrl_t   c2_next;
    logic [W-1:0]     res2_next;
    logic [NUM_W-1:0] num2_next;
    logic [W-1:0]     dmag2_next;
    logic signed [2*W-1:0] mul_sh;
    logic [W-1:0]     amag;
    logic [NUM_W-1:0] num_ext;

    fpa_pkg::ctrl_t   ch_ctrl [0:NUM_W];
    logic [NUM_W-1:0] ch_num  [0:NUM_W];
    logic [W-1:0]     ch_dmag [0:NUM_W];
    logic [W-1:0]     ch_rem  [0:NUM_W];
    logic [W-1:0]     ch_res  [0:NUM_W];

    fpa_pkg::ctrl_t   c2_reg;
    logic [W-1:0]     res2_reg;
    logic [NUM_W-1:0] num2_reg;
    logic [W-1:0]     dmag2_reg;

    logic             done_reg;
    logic             dz_reg;
    logic [W-1:0]     out_reg;
    logic [W-1:0]     out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg <= fpa_pkg::FRAC_RESET;
        end
        else if (cfg_valid)
        begin
            frac_reg <= cfg_data;
        end
    end

    // stage 0: capture, stage 1: multiply
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            c2_reg <= '0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            c2_reg <= c2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op0_reg   <= operation;
        a0_reg    <= operand_a[W-1:0];
        b0_reg    <= operand_b[W-1:0];
        fb0_reg   <= frac_reg;
        op1_reg   <= op0_reg;
        a1_reg    <= a0_reg;
        b1_reg    <= b0_reg;
        fb1_reg   <= fb0_reg;
        prod_reg  <= (2*W)'(a0_reg) * (2*W)'(b0_reg);
        res2_reg  <= res2_next;
        num2_reg  <= num2_next;
        dmag2_reg <= dmag2_next;
    end

    // stage 2: simple ops, product scaling, divider set-up
    always_comb
    begin
        mul_sh     = prod_reg >>> fb1_reg;
        amag       = a1_reg[W-1] ? -a1_reg : a1_reg;
        num_ext    = NUM_W'(amag);
        num2_next  = num_ext << fb1_reg;
        dmag2_next = b1_reg[W-1] ? -b1_reg : b1_reg;
        c2_next    = '0;
        c2_next.valid = v1_reg;
        c2_next.neg   = a1_reg[W-1] ^ b1_reg[W-1];
        res2_next  = '0;
        unique case (op1_reg)
            fpa_pkg::OP_ADD:  res2_next = a1_reg + b1_reg;
            fpa_pkg::OP_SUB:  res2_next = a1_reg - b1_reg;
            fpa_pkg::OP_NEG:  res2_next = -a1_reg;
            fpa_pkg::OP_MUL:  res2_next = mul_sh[W-1:0];
            fpa_pkg::OP_DIV:
            begin
                if (b1_reg == '0)
                begin
                    c2_next.dz = 1'b1;
                end
                else
                begin
                    c2_next.is_div = 1'b1;
                end
            end
            fpa_pkg::OP_CONV: res2_next = a1_reg << fb1_reg;
            default:          res2_next = '0;
        endcase
    end

    assign ch_ctrl[0] = c2_reg;
    assign ch_num[0]  = num2_reg;
    assign ch_dmag[0] = dmag2_reg;
    assign ch_rem[0]  = '0;
    assign ch_res[0]  = res2_reg;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        fpa_div_cell #(
            .W     (W),
            .NUM_W (NUM_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ch_ctrl[i]),
            .num_in   (ch_num[i]),
            .dmag_in  (ch_dmag[i]),
            .rem_in   (ch_rem[i]),
            .res_in   (ch_res[i]),
            .ctrl_out (ch_ctrl[i+1]),
            .num_out  (ch_num[i+1]),
            .dmag_out (ch_dmag[i+1]),
            .rem_out  (ch_rem[i+1]),
            .res_out  (ch_res[i+1])
        );
    end

    assign out_next = (ch_ctrl[NUM_W].is_div && ch_ctrl[NUM_W].neg)
                      ? -ch_res[NUM_W] : ch_res[NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= ch_ctrl[NUM_W].valid;
            dz_reg   <= ch_ctrl[NUM_W].valid & ch_ctrl[NUM_W].dz;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = done_reg;
    assign result       = 32'(signed'(out_reg));
    assign div_by_zero  = dz_reg;

endmodule

/* src/fpa_div_cell.sv */
// One cell of the divider chain: one quotient bit per cell, registered.
// Depends on fpa_pkg (ctrl_t).
module fpa_div_cell #(
    parameter int W     = fpa_pkg::DATA_WIDTH_DEF,
    parameter int NUM_W = fpa_pkg::DATA_WIDTH_DEF + fpa_pkg::MAX_FRAC
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpa_pkg::ctrl_t    ctrl_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [W-1:0]      dmag_in,
    input  logic [W-1:0]      rem_in,
    input  logic [W-1:0]      res_in,
    output fpa_pkg::ctrl_t    ctrl_out,
    output logic [NUM_W-1:0]  num_out,
    output logic [W-1:0]      dmag_out,
    output logic [W-1:0]      rem_out,
    output logic [W-1:0]      res_out
);

    fpa_pkg::ctrl_t   ctrl_reg;
    logic [NUM_W-1:0] num_reg;
    logic [W-1:0]     dmag_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     res_reg;

    logic [W:0]       rem_sh;
    logic [W+1:0]     diff;
    logic             ge;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     res_next;

    always_comb
    begin
        rem_sh   = {rem_in, num_in[NUM_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dmag_in};
        ge       = !diff[W+1];
        rem_next = ge ? diff[W-1:0] : rem_sh[W-1:0];
        res_next = ctrl_in.is_div ? {res_in[W-2:0], ge} : res_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_in << 1;
        dmag_reg <= dmag_in;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
    end

    assign ctrl_out = ctrl_reg;
    assign num_out  = num_reg;
    assign dmag_out = dmag_reg;
    assign rem_out  = rem_reg;
    assign res_out  = res_reg;

endmodule

/* src/fpa_checker.sv */
// Port-level checks for fixed_point_alu_core, bound to the top level.
// Depends on fpa_pkg and fixed_point_alu_core.
module fpa_checker #(
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input logic signed [31:0] result,
    input logic               div_by_zero
);

    localparam int LAT = DATA_WIDTH + fpa_pkg::MAX_FRAC + fpa_pkg::PIPE_EXTRA;

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT result_valid)
        else $error("accepted beat gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching beat");

    a_dz_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        div_by_zero |-> result_valid)
        else $error("div_by_zero outside a result");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        div_by_zero |-> result == 32'sd0)
        else $error("division by zero gave nonzero result");

endmodule

bind fixed_point_alu_core fpa_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_fpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .div_by_zero  (div_by_zero)
);
